// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl
// each macro names a clock and a reset of its own module by the fixed names clk and rst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, prop, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/iole_pkg.sv =====
package iole_pkg;

  // list geometry
  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;
  localparam int KIND_W     = 3;
  localparam int POS_W      = 5;
  localparam int VAL_W      = 32;
  localparam int STAT_W     = 2;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

  // request codes
  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_INSERT_AT  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_REMOVE_AT  = 3'd5;
  localparam logic [KIND_W-1:0] KIND_FIND       = 3'd6;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

  // what one cell takes in on a step
  typedef enum logic [1:0] {
    SEL_HOLD,
    SEL_PREV,
    SEL_NEXT,
    SEL_LOAD
  } cell_sel_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  position;
    logic [VAL_W-1:0]  value;
  } in_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              found;
    logic [POS_W-1:0]  found_index;
    logic [VAL_W-1:0]  front_value;
    logic [VAL_W-1:0]  back_value;
    logic [POS_W-1:0]  item_count;
    logic              is_empty;
  } out_t;

  // decoded request, from the controller to the cell row
  typedef struct packed {
    logic              do_ins;
    logic              do_rem;
    logic              is_find;
    logic [CMP_W-1:0]  at;
    logic [CNT_W-1:0]  count_nxt;
    logic [STAT_W-1:0] status;
  } cmd_t;

endpackage

// ===== rtl/iole_cell.sv =====
module iole_cell (
  input  logic                            clk,
  input  iole_pkg::cell_sel_t             sel,
  input  logic [iole_pkg::DATA_WIDTH-1:0] prev_val,
  input  logic [iole_pkg::DATA_WIDTH-1:0] next_val,
  input  logic [iole_pkg::DATA_WIDTH-1:0] load_val,
  output logic [iole_pkg::DATA_WIDTH-1:0] val_r,
  output logic [iole_pkg::DATA_WIDTH-1:0] val_nxt
);

  // pick the incoming value
  always_comb begin
    case (sel)
      iole_pkg::SEL_PREV: val_nxt = prev_val;
      iole_pkg::SEL_NEXT: val_nxt = next_val;
      iole_pkg::SEL_LOAD: val_nxt = load_val;
      default:            val_nxt = val_r;
    endcase
  end

  // stored value
  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

// ===== rtl/iole_ctrl.sv =====
module iole_ctrl (
  input  iole_pkg::in_t                req,
  input  logic [iole_pkg::CNT_W-1:0]   count_r,
  output iole_pkg::cmd_t               cmd
);

  logic [iole_pkg::CMP_W-1:0] cnt_ext;
  logic [iole_pkg::CMP_W-1:0] pos_ext;
  logic [iole_pkg::CMP_W-1:0] ins_at;
  logic                       is_ins;
  logic                       full;

  assign cnt_ext = iole_pkg::CMP_W'(count_r);
  assign pos_ext = iole_pkg::CMP_W'(req.position);
  assign full    = (count_r == iole_pkg::CNT_W'(iole_pkg::CAPACITY));

  // insert position for the three insert flavours
  always_comb begin
    is_ins = 1'b0;
    ins_at = '0;
    case (req.kind)
      iole_pkg::KIND_PUSH_FRONT: begin
        is_ins = 1'b1;
        ins_at = '0;
      end
      iole_pkg::KIND_PUSH_BACK: begin
        is_ins = 1'b1;
        ins_at = cnt_ext;
      end
      iole_pkg::KIND_INSERT_AT: begin
        is_ins = 1'b1;
        ins_at = pos_ext;
      end
      default: begin
        is_ins = 1'b0;
        ins_at = '0;
      end
    endcase
  end

  // decode request against the current count
  always_comb begin
    cmd           = '0;
    cmd.count_nxt = count_r;
    cmd.status    = iole_pkg::ST_OK;
    if (is_ins) begin
      cmd.at = ins_at;
      if (ins_at > cnt_ext) begin
        cmd.status = iole_pkg::ST_RANGE;
      end else if (full) begin
        cmd.status = iole_pkg::ST_FULL;
      end else begin
        cmd.do_ins    = 1'b1;
        cmd.count_nxt = count_r + 1'b1;
      end
    end else begin
      case (req.kind)
        iole_pkg::KIND_POP_FRONT: begin
          if (count_r == '0) begin
            cmd.status = iole_pkg::ST_EMPTY;
          end else begin
            cmd.do_rem    = 1'b1;
            cmd.count_nxt = count_r - 1'b1;
          end
        end
        iole_pkg::KIND_POP_BACK: begin
          // tail cell simply drops out of range, nothing shifts
          if (count_r == '0) begin
            cmd.status = iole_pkg::ST_EMPTY;
          end else begin
            cmd.count_nxt = count_r - 1'b1;
          end
        end
        iole_pkg::KIND_REMOVE_AT: begin
          cmd.at = pos_ext;
          if (pos_ext >= cnt_ext) begin
            cmd.status = iole_pkg::ST_RANGE;
          end else begin
            cmd.do_rem    = 1'b1;
            cmd.count_nxt = count_r - 1'b1;
          end
        end
        iole_pkg::KIND_FIND: begin
          cmd.is_find = 1'b1;
        end
        default: begin
          cmd.is_find = 1'b0;
        end
      endcase
    end
  end

endmodule

// ===== rtl/indexed_ordered_list_engine.sv =====
// indexed ordered list engine
// keeps an ordered list of up to 16 values in a row of cells plus a count;
// each input beat on in_data carries one request (push/pop at either end,
// insert or remove at an index, or find a value), each gives one result beat
// on out_data with the status, find outcome, front, back, count and empty flag
// both channels are valid/ready; a request is accepted when in_valid and
// in_ready are high at a clock edge
// the result beat is registered and shows on the cycle after the request is
// accepted; all cells shift, compare and load together at the accepting edge
// throughput: one request per cycle while out_ready stays high
// when the receiver stalls the result waits in the output register and
// in_ready drops until it has been taken
// reset (rst_n low at a clock edge) empties the list and drops the result;
// cell contents are not cleared, the count alone marks which cells are live
`include "assert_macros.svh"

module indexed_ordered_list_engine (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  iole_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output iole_pkg::out_t out_data
);

  localparam int N = iole_pkg::CAPACITY;

  logic                             accept;
  logic [iole_pkg::CNT_W-1:0]       count_r;
  logic [iole_pkg::CNT_W-1:0]       count_nxt;
  logic                             out_valid_r;
  logic                             out_valid_nxt;
  iole_pkg::out_t                   out_r;
  iole_pkg::out_t                   out_nxt;
  iole_pkg::cmd_t                   cmd;
  logic [iole_pkg::DATA_WIDTH-1:0]  key;
  logic [iole_pkg::DATA_WIDTH-1:0]  cell_val [N];
  logic [iole_pkg::DATA_WIDTH-1:0]  cell_nxt [N];
  iole_pkg::cell_sel_t              cell_sel [N];
  logic [N-1:0]                     match;
  logic [N-1:0]                     is_last;
  logic                             hit;
  logic [iole_pkg::CMP_W-1:0]       hit_idx;
  logic [iole_pkg::DATA_WIDTH-1:0]  back_val;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign key       = iole_pkg::DATA_WIDTH'(in_data.value);

  // request decode
  iole_ctrl u_ctrl (
    .req     (in_data),
    .count_r (count_r),
    .cmd     (cmd)
  );

  // row of cells
  for (genvar i = 0; i < N; i++) begin : g_cell
    localparam logic [iole_pkg::CMP_W-1:0] IDX = iole_pkg::CMP_W'(i);
    logic [iole_pkg::DATA_WIDTH-1:0] prev_v;
    logic [iole_pkg::DATA_WIDTH-1:0] next_v;

    if (i == 0) begin : g_first
      assign prev_v = cell_val[i];
    end else begin : g_mid
      assign prev_v = cell_val[i-1];
    end
    if (i == N - 1) begin : g_end
      assign next_v = cell_val[i];
    end else begin : g_inner
      assign next_v = cell_val[i+1];
    end

    // per-cell move: open a gap or close one at the request index
    always_comb begin
      cell_sel[i] = iole_pkg::SEL_HOLD;
      if (accept && cmd.do_ins) begin
        if (IDX > cmd.at) begin
          cell_sel[i] = iole_pkg::SEL_PREV;
        end else if (IDX == cmd.at) begin
          cell_sel[i] = iole_pkg::SEL_LOAD;
        end
      end else if (accept && cmd.do_rem) begin
        if (IDX >= cmd.at) begin
          cell_sel[i] = iole_pkg::SEL_NEXT;
        end
      end
    end

    iole_cell u_cell (
      .clk      (clk),
      .sel      (cell_sel[i]),
      .prev_val (prev_v),
      .next_val (next_v),
      .load_val (key),
      .val_r    (cell_val[i]),
      .val_nxt  (cell_nxt[i])
    );

    // compare against the search key, live cells only
    assign match[i]   = (cell_val[i] == key) &&
                        (IDX < iole_pkg::CMP_W'(count_r));
    // tail marker after the step
    assign is_last[i] = (iole_pkg::CMP_W'(i + 1) == iole_pkg::CMP_W'(cmd.count_nxt));
  end

  // first matching cell
  always_comb begin
    hit     = |match;
    hit_idx = iole_pkg::CMP_W'(count_r);
    for (int i = N - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx = iole_pkg::CMP_W'(i);
      end
    end
  end

  // back value through the one-hot tail marker
  always_comb begin
    back_val = '0;
    for (int i = 0; i < N; i++) begin
      back_val = back_val | (cell_nxt[i] & {iole_pkg::DATA_WIDTH{is_last[i]}});
    end
  end

  // result beat
  always_comb begin
    out_nxt             = '0;
    out_nxt.status      = cmd.status;
    out_nxt.found       = cmd.is_find && hit;
    out_nxt.found_index = cmd.is_find ? iole_pkg::POS_W'(hit_idx) : '0;
    out_nxt.item_count  = iole_pkg::POS_W'(cmd.count_nxt);
    out_nxt.is_empty    = (cmd.count_nxt == '0);
    if (cmd.count_nxt != '0) begin
      out_nxt.front_value = iole_pkg::VAL_W'(cell_nxt[0]);
      out_nxt.back_value  = iole_pkg::VAL_W'(back_val);
    end
  end

  always_comb begin
    count_nxt     = accept ? cmd.count_nxt : count_r;
    out_valid_nxt = accept ? 1'b1 : (out_valid_r && !out_ready);
  end

  // count and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= out_nxt;
    end
  end

  // checks
  `ASSERT_ALWAYS(a_count_cap, count_r <= iole_pkg::CNT_W'(iole_pkg::CAPACITY), "count above capacity")
  `ASSERT_ALWAYS(a_tail_onehot, $onehot0(is_last), "more than one tail cell")
  `ASSERT_NEXT(a_accept_result, accept, out_valid_r && (out_r.item_count == iole_pkg::POS_W'(count_r)), "result missing or count mismatch")
  `ASSERT_NEXT(a_stall_count, !accept, $stable(count_r), "count moved without a request")

endmodule

// ===== verif/iole_checker.sv =====
`timescale 1ns / 100ps

module iole_checker
  import iole_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_ready,
  input  in_t  in_data,
  input  logic out_valid,
  input  logic out_ready,
  input  out_t out_data,
  output int   fail_count,
  output int   pending_results
);

  localparam int AWAIT_DEPTH = 16;

  // shadow copy of the list
  logic [VAL_W-1:0] list_cells [CAPACITY];
  int               list_count;

  // results still owed by the block, kept in a small ring, oldest at the read slot
  out_t awaited_results [AWAIT_DEPTH];
  int   await_wr;
  int   await_rd;
  int   await_level;
  out_t newest_result;
  out_t oldest_result;
  int   mismatch_total;
  int   result_beats;
  bit   field_bad;

  // open a gap at the index and drop the value in
  function automatic logic [STAT_W-1:0] insert_value(int at, logic [VAL_W-1:0] v);
    int i;
    if (at > list_count) begin
      return ST_RANGE;
    end
    if (list_count >= CAPACITY) begin
      return ST_FULL;
    end
    for (i = list_count; i > at; i--) begin
      list_cells[i] = list_cells[i-1];
    end
    list_cells[at] = v;
    list_count++;
    return ST_OK;
  endfunction

  // close the gap left at the index
  function automatic void remove_value(int at);
    int i;
    for (i = at; i + 1 < list_count; i++) begin
      list_cells[i] = list_cells[i+1];
    end
    list_count--;
  endfunction

  // apply one request to the shadow list and work out its result beat
  function automatic out_t apply_list_request(in_t req);
    out_t res;
    int   i;
    res        = '0;
    res.status = ST_OK;
    case (req.kind)
      KIND_PUSH_FRONT: res.status = insert_value(0, req.value);
      KIND_PUSH_BACK:  res.status = insert_value(list_count, req.value);
      KIND_INSERT_AT:  res.status = insert_value(int'(req.position), req.value);
      KIND_POP_FRONT: begin
        if (list_count == 0) res.status = ST_EMPTY;
        else remove_value(0);
      end
      KIND_POP_BACK: begin
        if (list_count == 0) res.status = ST_EMPTY;
        else list_count--;
      end
      KIND_REMOVE_AT: begin
        if (int'(req.position) >= list_count) res.status = ST_RANGE;
        else remove_value(int'(req.position));
      end
      KIND_FIND: begin
        // first match wins, count when nothing matches
        res.found_index = POS_W'(list_count);
        for (i = list_count - 1; i >= 0; i--) begin
          if (list_cells[i] == req.value) begin
            res.found       = 1'b1;
            res.found_index = POS_W'(i);
          end
        end
      end
      default: ;
    endcase
    res.front_value = (list_count != 0) ? list_cells[0] : '0;
    res.back_value  = (list_count != 0) ? list_cells[list_count-1] : '0;
    res.item_count  = POS_W'(list_count);
    res.is_empty    = (list_count == 0);
    return res;
  endfunction

  // watch both channels
  always @(posedge clk) begin
    if (!rst_n) begin
      list_count      = 0;
      mismatch_total  = 0;
      result_beats    = 0;
      await_wr        = 0;
      await_rd        = 0;
      await_level     = 0;
      fail_count      <= 0;
      pending_results <= 0;
    end else begin
      if (in_valid && in_ready) begin
        newest_result = apply_list_request(in_data);
        if (await_level == AWAIT_DEPTH) begin
          mismatch_total++;
          if (mismatch_total <= 10) begin
            $display("request beat taken with %0d results already owed", await_level);
          end
        end else begin
          awaited_results[await_wr] = newest_result;
          await_wr = (await_wr + 1) % AWAIT_DEPTH;
          await_level++;
        end
      end
      if (out_valid && out_ready) begin
        result_beats++;
        if (await_level == 0) begin
          mismatch_total++;
          if (mismatch_total <= 10) begin
            $display("result beat %0d arrived with nothing awaited", result_beats);
          end
        end else begin
          oldest_result = awaited_results[await_rd];
          await_rd = (await_rd + 1) % AWAIT_DEPTH;
          await_level--;
          field_bad = (out_data.status !== oldest_result.status)
                   || (out_data.found !== oldest_result.found)
                   || (out_data.found_index !== oldest_result.found_index)
                   || (out_data.front_value !== oldest_result.front_value)
                   || (out_data.back_value !== oldest_result.back_value)
                   || (out_data.item_count !== oldest_result.item_count)
                   || (out_data.is_empty !== oldest_result.is_empty);
          if (field_bad) begin
            mismatch_total++;
            if (mismatch_total <= 10) begin
              $display({"result beat %0d mismatch, expected: ",
                        "st %0d fnd %0b idx %0d front %h back %h cnt %0d emp %0b"},
                       result_beats, oldest_result.status, oldest_result.found,
                       oldest_result.found_index, oldest_result.front_value,
                       oldest_result.back_value, oldest_result.item_count,
                       oldest_result.is_empty);
              $display("  actual: st %0d fnd %0b idx %0d front %h back %h cnt %0d emp %0b",
                       out_data.status, out_data.found, out_data.found_index,
                       out_data.front_value, out_data.back_value, out_data.item_count,
                       out_data.is_empty);
            end
          end
        end
      end
      fail_count      <= mismatch_total;
      pending_results <= await_level;
    end
  end

endmodule

// ===== verif/tb_indexed_ordered_list_engine.sv =====
`timescale 1ns / 100ps

module tb_indexed_ordered_list_engine;
  import iole_pkg::*;

  // the one code the package leaves unnamed
  localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;
  localparam int RANDOM_REQUESTS = 1100;
  localparam int LONG_HOLD_CYCLES = 400;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  int   fail_count;
  int   pending_results;

  // stimulus steering
  int   shadow_count;
  bit   no_gap_mode;
  bit   grow_mode;
  bit   long_hold_req;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  indexed_ordered_list_engine i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  iole_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  // mostly back to back, sometimes a short gap, rarely a long pause
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gap_mode || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // small pool so finds hit, plus the extremes and full random words
  function automatic logic [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return VAL_W'($urandom_range(0, 7));
    if (r < 55) return '1 - VAL_W'($urandom_range(0, 3));
    return $urandom;
  endfunction

  // offer one request beat and hold it until taken
  task automatic send_request(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
                              input logic [VAL_W-1:0] v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{kind: kind, position: pos, value: v};
    do @(posedge clk); while (!in_ready);
    // rough fill level, only for steering positions
    case (kind)
      KIND_PUSH_FRONT, KIND_PUSH_BACK: if (shadow_count < CAPACITY) shadow_count++;
      KIND_INSERT_AT: if (pos <= shadow_count && shadow_count < CAPACITY) shadow_count++;
      KIND_POP_FRONT, KIND_POP_BACK: if (shadow_count > 0) shadow_count--;
      KIND_REMOVE_AT: if (pos < shadow_count) shadow_count--;
      default: ;
    endcase
  endtask

  // receiver: random stalls, ready stretches and one long hold-off on request
  initial begin
    int r;
    wait (rst_n === 1'b1);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          out_ready <= 1'b1;
          repeat ($urandom_range(1, 4)) @(posedge clk);
        end else if (r < 85) begin
          out_ready <= 1'b0;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end else if (r < 93) begin
          out_ready <= 1'b1;
          repeat ($urandom_range(20, 120)) @(posedge clk);
        end else begin
          out_ready <= 1'b0;
          repeat ($urandom_range(10, 60)) @(posedge clk);
        end
      end
    end
  end

  // stimulus and verdict
  initial begin
    int i;
    int r;
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  pos;
    shadow_count  = 0;
    no_gap_mode   = 1'b0;
    grow_mode     = 1'b1;
    long_hold_req = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // empty list corner cases
    send_request(KIND_POP_FRONT, 5'd0, '0);
    send_request(KIND_POP_BACK, 5'd31, '1);
    send_request(KIND_REMOVE_AT, 5'd0, '0);
    send_request(KIND_FIND, 5'd0, '0);
    send_request(KIND_INSERT_AT, 5'd1, 32'h1);

    // fill to capacity through every way in
    for (i = 0; i < CAPACITY; i++) begin
      case (i % 4)
        0: send_request(KIND_PUSH_FRONT, '0, (i == 0) ? '1 : $urandom);
        1: send_request(KIND_PUSH_BACK, '1, (i == 1) ? '0 : $urandom);
        2: send_request(KIND_INSERT_AT, POS_W'(shadow_count), pick_value());
        default: send_request(KIND_INSERT_AT, (i % 8 == 3) ? '0 : POS_W'(shadow_count / 2),
                              pick_value());
      endcase
    end

    // full list: range check comes before the full check
    send_request(KIND_PUSH_BACK, '0, 32'h5a5a_5a5a);
    send_request(KIND_INSERT_AT, 5'd17, 32'ha5a5_a5a5);
    send_request(KIND_INSERT_AT, 5'd16, 32'h0);
    send_request(KIND_FIND, '0, '1);
    send_request(KIND_UNUSED, 5'd31, '1);
    send_request(KIND_REMOVE_AT, 5'd16, '0);
    send_request(KIND_REMOVE_AT, 5'd15, '0);
    send_request(KIND_REMOVE_AT, 5'd0, '0);
    send_request(KIND_POP_FRONT, '0, '0);
    send_request(KIND_POP_BACK, '0, '0);

    // random traffic swinging between full and empty
    for (i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i % 64 == 0) no_gap_mode = ($urandom_range(0, 3) == 0);
      if (i == 100 || i == 650) long_hold_req = 1'b1;
      if (shadow_count == CAPACITY) grow_mode = 1'b0;
      else if (shadow_count == 0) grow_mode = 1'b1;
      else if ($urandom_range(0, 49) == 0) grow_mode = !grow_mode;

      r = $urandom_range(0, 99);
      if (r < 3) begin
        kind = KIND_UNUSED;
      end else if (r < 25) begin
        kind = KIND_FIND;
      end else if ((r < 80) == grow_mode) begin
        case ($urandom_range(0, 2))
          0: kind = KIND_PUSH_FRONT;
          1: kind = KIND_PUSH_BACK;
          default: kind = KIND_INSERT_AT;
        endcase
      end else begin
        case ($urandom_range(0, 2))
          0: kind = KIND_POP_FRONT;
          1: kind = KIND_POP_BACK;
          default: kind = KIND_REMOVE_AT;
        endcase
      end

      // mostly legal indexes, some just past the end, some anything
      r = $urandom_range(0, 99);
      if (r < 10) pos = POS_W'($urandom_range(0, 31));
      else if (kind == KIND_INSERT_AT)
        pos = (r < 85) ? POS_W'($urandom_range(0, shadow_count)) : POS_W'(shadow_count + 1);
      else if (kind == KIND_REMOVE_AT && shadow_count > 0 && r < 85)
        pos = POS_W'($urandom_range(0, shadow_count - 1));
      else if (kind == KIND_REMOVE_AT)
        pos = POS_W'(shadow_count + $urandom_range(0, 2));
      else
        pos = POS_W'($urandom_range(0, 31));

      send_request(kind, pos, pick_value());
    end
    in_valid <= 1'b0;

    // drain what is still owed, then let the bench settle before the verdict
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/iole_pkg.sv
rtl/iole_cell.sv
rtl/iole_ctrl.sv
rtl/indexed_ordered_list_engine.sv
verif/iole_checker.sv
verif/tb_indexed_ordered_list_engine.sv
